@@ hdl/log_record_stream_checker_defines.svh @@
// ----------------------------------------------------------------------------
// log record stream checker assertion macros
// same-cycle and next-cycle implication checks clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_STREAM_CHECKER_DEFINES_SVH
`define LOG_RECORD_STREAM_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define LRSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LRSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LRSC_ASSERT_SAME(label, ante, cons, msg)

`define LRSC_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ hdl/lrsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrsc_pkg
// shared types, codes and the byte-wide crc-32 update for the record checker
// ----------------------------------------------------------------------------
package lrsc_pkg;

    localparam int HEADER_BYTES = 20;
    localparam int CRC_BYTES    = 4;

    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_MAGIC  = 2'd1;
    localparam t_status ST_LENGTH = 2'd2;
    localparam t_status ST_CRC    = 2'd3;

    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_RECORD_MAGIC = 1'b0;
    localparam t_cfg_index CFG_MAX_PAYLOAD  = 1'b1;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd65532;

    typedef struct packed {
        logic [31:0] record_magic;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_word;

    // reflected crc over one byte, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hdl/lrsc_in_if.sv @@
// ----------------------------------------------------------------------------
// lrsc_in_if
// input channel: one stream byte and its restart flag per word
// ----------------------------------------------------------------------------
interface lrsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink (input valid, input data_byte, input restart, output ready);
endinterface

@@ hdl/lrsc_out_if.sv @@
// ----------------------------------------------------------------------------
// lrsc_out_if
// result channel: one record verdict per word
// ----------------------------------------------------------------------------
interface lrsc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] record_offset;
    logic [63:0] stamp;
    logic [31:0] payload_length;
    logic [31:0] valid_records;

    modport source (output valid, output status, output record_offset, output stamp,
                    output payload_length, output valid_records, input ready);
    modport sink (input valid, input status, input record_offset, input stamp,
                  input payload_length, input valid_records, output ready);
endinterface

@@ hdl/lrsc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lrsc_cfg_regs
// configuration registers: expected magic and payload length limit
// ----------------------------------------------------------------------------
module lrsc_cfg_regs
    import lrsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_cfg_index i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_magic <= 32'd0;
            r_cfg.max_payload  <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RECORD_MAGIC: begin
                    r_cfg.record_magic <= i_cfg_data;
                end
                CFG_MAX_PAYLOAD: begin
                    r_cfg.max_payload <= i_cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/lrsc_in_reg.sv @@
// ----------------------------------------------------------------------------
// lrsc_in_reg
// input register stage, refills in the same cycle the parser takes its word
// ----------------------------------------------------------------------------
module lrsc_in_reg
    import lrsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    lrsc_in_if.sink  i_in,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_word o_word
);

    logic     r_valid;
    t_in_word r_word;
    logic     accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_word.data_byte <= i_in.data_byte;
            r_word.restart   <= i_in.restart;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

@@ hdl/lrsc_parser.sv @@
// ----------------------------------------------------------------------------
// lrsc_parser
// record framing, field capture, crc check and the result register
// ----------------------------------------------------------------------------
`include "log_record_stream_checker_defines.svh"

module lrsc_parser
    import lrsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  t_in_word    i_word,
    output logic        o_take,
    lrsc_out_if.source  o_out
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC,
        PH_STOP
    } t_phase;

    typedef logic [4:0] t_pos;

    localparam t_pos MAGIC_END   = 5'd4;
    localparam t_pos STAMP_END   = 5'd12;
    localparam t_pos LENGTH_END  = 5'd16;
    localparam t_pos HEADER_LAST = t_pos'(HEADER_BYTES - 1);
    localparam t_pos CRC_LAST    = t_pos'(CRC_BYTES - 1);

    t_phase      r_phase, n_phase, cur_phase;
    t_pos        r_pos, n_pos, cur_pos;
    logic [31:0] r_magic, n_magic;
    logic [63:0] r_stamp, n_stamp;
    logic [31:0] r_length, n_length;
    logic [15:0] r_left, n_left, cur_left, left_dec;
    logic [31:0] r_crc, n_crc, cur_crc;
    logic [31:0] r_stored, n_stored, cur_stored;
    logic [31:0] r_offset, n_offset, cur_offset;
    logic [31:0] r_start, n_start;
    logic [31:0] r_count, n_count, cur_count;

    logic        emit;
    t_status     emit_status;

    logic        r_out_valid;
    t_status     r_out_status;
    logic [31:0] r_out_offset;
    logic [63:0] r_out_stamp;
    logic [31:0] r_out_length;
    logic [31:0] r_out_count;

    logic [7:0]  b;

    assign b      = i_word.data_byte;
    assign o_take = i_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        // restart clears framing before the byte is taken as header byte 0
        cur_phase  = r_phase;
        cur_pos    = r_pos;
        cur_left   = r_left;
        cur_crc    = r_crc;
        cur_stored = r_stored;
        cur_offset = r_offset;
        cur_count  = r_count;
        n_start    = r_start;
        if (i_word.restart) begin
            cur_phase  = PH_HEADER;
            cur_pos    = '0;
            cur_left   = '0;
            cur_crc    = CRC_INIT;
            cur_stored = '0;
            cur_offset = '0;
            cur_count  = '0;
            n_start    = '0;
        end

        n_phase     = cur_phase;
        n_pos       = cur_pos;
        n_left      = cur_left;
        n_crc       = cur_crc;
        n_stored    = cur_stored;
        n_count     = cur_count;
        n_magic     = r_magic;
        n_stamp     = r_stamp;
        n_length    = r_length;
        n_offset    = cur_offset + 32'd1;
        emit        = 1'b0;
        emit_status = ST_OK;
        left_dec    = (cur_left != 16'd0) ? (cur_left - 16'd1) : cur_left;

        unique case (cur_phase)
            PH_HEADER: begin
                n_crc = crc_byte(cur_crc, b);
                if (cur_pos == '0) begin
                    n_start = cur_offset;
                end
                if (cur_pos < MAGIC_END) begin
                    n_magic = {r_magic[23:0], b};
                end else if (cur_pos < STAMP_END) begin
                    n_stamp = {r_stamp[55:0], b};
                end else if (cur_pos < LENGTH_END) begin
                    n_length = {r_length[23:0], b};
                end
                if (cur_pos == HEADER_LAST) begin
                    n_pos = '0;
                    if (n_magic != i_cfg.record_magic) begin
                        emit        = 1'b1;
                        emit_status = ST_MAGIC;
                        n_phase     = PH_STOP;
                    end else if (n_length > {16'd0, i_cfg.max_payload}) begin
                        emit        = 1'b1;
                        emit_status = ST_LENGTH;
                        n_phase     = PH_STOP;
                    end else if (n_length == 32'd0) begin
                        n_phase = PH_CRC;
                    end else begin
                        n_left  = n_length[15:0];
                        n_phase = PH_PAYLOAD;
                    end
                end else begin
                    n_pos = cur_pos + 5'd1;
                end
            end
            PH_PAYLOAD: begin
                n_crc  = crc_byte(cur_crc, b);
                n_left = left_dec;
                if (left_dec == 16'd0) begin
                    n_pos   = '0;
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                n_stored = {cur_stored[23:0], b};
                if (cur_pos == CRC_LAST) begin
                    emit = 1'b1;
                    if ((cur_crc ^ CRC_XOROUT) == n_stored) begin
                        emit_status = ST_OK;
                        if (cur_count != '1) begin
                            n_count = cur_count + 32'd1;
                        end
                        n_phase  = PH_HEADER;
                        n_pos    = '0;
                        n_crc    = CRC_INIT;
                        n_stored = '0;
                        n_left   = '0;
                    end else begin
                        emit_status = ST_CRC;
                        n_pos       = '0;
                        n_phase     = PH_STOP;
                    end
                end else begin
                    n_pos = cur_pos + 5'd1;
                end
            end
            PH_STOP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_offset    <= '0;
            r_count     <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_crc    <= n_crc;
                r_offset <= n_offset;
                r_count  <= n_count;
                r_start  <= n_start;
            end
            if (o_take && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_take) begin
            r_magic  <= n_magic;
            r_stamp  <= n_stamp;
            r_length <= n_length;
            r_left   <= n_left;
            r_stored <= n_stored;
        end
        if (o_take && emit) begin
            r_out_status <= emit_status;
            r_out_offset <= n_start;
            r_out_stamp  <= n_stamp;
            r_out_length <= n_length;
            r_out_count  <= n_count;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.record_offset  = r_out_offset;
    assign o_out.stamp          = r_out_stamp;
    assign o_out.payload_length = r_out_length;
    assign o_out.valid_records  = r_out_count;

    `LRSC_ASSERT_SAME(a_header_pos, r_phase == PH_HEADER, r_pos <= HEADER_LAST, "header position out of range")
    `LRSC_ASSERT_SAME(a_crc_pos, r_phase == PH_CRC, r_pos <= CRC_LAST, "crc position out of range")
    `LRSC_ASSERT_NEXT(a_stop_holds, (r_phase == PH_STOP) && !(o_take && i_word.restart), r_phase == PH_STOP, "left stop without restart")
    `LRSC_ASSERT_NEXT(a_count_step, o_take && emit && (emit_status == ST_OK) && !i_word.restart && (r_count != '1), r_count == $past(r_count) + 32'd1, "valid record not counted")
    `LRSC_ASSERT_NEXT(a_offset_step, o_take && !i_word.restart, r_offset == $past(r_offset) + 32'd1, "stream offset did not advance")

endmodule

@@ hdl/log_record_stream_checker.sv @@
// ----------------------------------------------------------------------------
// log_record_stream_checker
// validates a byte stream of framed log records with a crc-32 trailer
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one stream byte per word, restart marks the first byte of a
//   new file. o_out carries one word per finished record: status, header
//   offset, timestamp, length field and the count of valid records.
//   configuration (expected magic, payload limit) is written through
//   i_cfg_we / i_cfg_index / i_cfg_data while the stream is idle.
// timing:
//   one byte per cycle sustained while the receiver takes each result. a byte
//   is held in the input register and its result, if any, is registered in
//   the output register once the parser takes that byte. the rate rests on
//   the byte-wide crc update and field shift, both combinational.
// reset and stall:
//   reset returns to the header of a record at offset zero with the count
//   cleared and the magic and limit at their defaults. when the receiver
//   holds off, the result waits in the output register while one more byte
//   is taken into the input register; then i_in.ready drops.
// ----------------------------------------------------------------------------
module log_record_stream_checker
    import lrsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrsc_in_if.sink     i_in,
    lrsc_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  t_cfg_index  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg     cfg;
    logic     word_valid;
    t_in_word word;
    logic     take;

    lrsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lrsc_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (word_valid),
        .o_word  (word)
    );

    lrsc_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (word_valid),
        .i_word  (word),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

@@ tb/log_record_stream_checker_test.sv @@
// ----------------------------------------------------------------------------
// log_record_stream_checker_test
// streams framed log records (good, bad magic, over-long, bad crc, truncated,
// restarted) through the checker under random stalls and compares every
// verdict word against a byte-by-byte scan kept in the bench
// ----------------------------------------------------------------------------
module log_record_stream_checker_test;
    import lrsc_pkg::*;

    localparam int CUT_NONE = 1 << 30;

    typedef enum logic [1:0] {SCAN_HEADER, SCAN_BODY, SCAN_TRAILER, SCAN_HALT} t_scan;

    typedef struct packed {
        t_status     status;
        logic [31:0] offset;
        logic [63:0] stamp;
        logic [31:0] length;
        logic [31:0] count;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    t_cfg_index  cfg_index = CFG_RECORD_MAGIC;
    logic [31:0] cfg_data = '0;

    lrsc_in_if  in_bus();
    lrsc_out_if out_bus();

    log_record_stream_checker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // bench copy of the registers
    logic [31:0] cfg_magic;
    logic [15:0] cfg_limit;

    // scan state of the checker as seen by the bench
    t_scan       scan_state;
    logic [4:0]  field_pos;
    logic [31:0] got_magic;
    logic [63:0] got_stamp;
    logic [31:0] got_length;
    logic [15:0] body_left;
    logic [31:0] crc_acc;
    logic [31:0] trailer_crc;
    logic [31:0] stream_pos;
    logic [31:0] rec_start;
    logic [31:0] good_count;

    t_verdict  expected_verdicts[$];
    t_in_word  byte_backlog[$];
    t_in_word  drive_word;
    int        pushed_bytes = 0;
    int        fail_count = 0;
    int        send_idle_pct = 35;
    int        recv_idle_pct = 70;
    logic      hold_req = 1'b0;
    logic      hold_done;
    int        hold_left;

    function automatic logic [31:0] crc32_shift(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic open_record();
        scan_state  = SCAN_HEADER;
        field_pos   = '0;
        crc_acc     = '1;
        trailer_crc = '0;
        body_left   = '0;
    endtask

    task automatic post_verdict(input t_status st);
        t_verdict v;
        v.status = st;
        v.offset = rec_start;
        v.stamp  = got_stamp;
        v.length = got_length;
        v.count  = good_count;
        expected_verdicts.push_back(v);
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic rs);
        if (rs) begin
            stream_pos = '0;
            good_count = '0;
            rec_start  = '0;
            open_record();
        end
        case (scan_state)
            SCAN_HEADER: begin
                if (field_pos == 0) rec_start = stream_pos;
                crc_acc = crc32_shift(crc_acc, b);
                if (field_pos < 4) got_magic = {got_magic[23:0], b};
                else if (field_pos < 12) got_stamp = {got_stamp[55:0], b};
                else if (field_pos < 16) got_length = {got_length[23:0], b};
                field_pos = field_pos + 1'b1;
                if (field_pos == 5'(HEADER_BYTES)) begin
                    field_pos = '0;
                    if (got_magic != cfg_magic) begin
                        post_verdict(ST_MAGIC);
                        scan_state = SCAN_HALT;
                    end else if (got_length > {16'd0, cfg_limit}) begin
                        post_verdict(ST_LENGTH);
                        scan_state = SCAN_HALT;
                    end else if (got_length == 0) begin
                        scan_state = SCAN_TRAILER;
                    end else begin
                        body_left  = got_length[15:0];
                        scan_state = SCAN_BODY;
                    end
                end
            end
            SCAN_BODY: begin
                crc_acc = crc32_shift(crc_acc, b);
                if (body_left != 0) body_left = body_left - 1'b1;
                if (body_left == 0) begin
                    field_pos  = '0;
                    scan_state = SCAN_TRAILER;
                end
            end
            SCAN_TRAILER: begin
                trailer_crc = {trailer_crc[23:0], b};
                field_pos   = field_pos + 1'b1;
                if (field_pos >= 5'(CRC_BYTES)) begin
                    if ((crc_acc ^ CRC_XOROUT) == trailer_crc) begin
                        if (good_count != '1) good_count = good_count + 1'b1;
                        post_verdict(ST_OK);
                        open_record();
                    end else begin
                        post_verdict(ST_CRC);
                        field_pos  = '0;
                        scan_state = SCAN_HALT;
                    end
                end
            end
            default: ;
        endcase
        stream_pos = stream_pos + 1'b1;
    endtask

    // driver: one word per accepted handshake, scan happens at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid     <= 1'b0;
            in_bus.data_byte <= '0;
            in_bus.restart   <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) scan_byte(in_bus.data_byte, in_bus.restart);
            if (!in_bus.valid || in_bus.ready) begin
                if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drive_word = byte_backlog.pop_front();
                    in_bus.valid     <= 1'b1;
                    in_bus.data_byte <= drive_word.data_byte;
                    in_bus.restart   <= drive_word.restart;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict seen;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                seen.status = out_bus.status;
                seen.offset = out_bus.record_offset;
                seen.stamp  = out_bus.stamp;
                seen.length = out_bus.payload_length;
                seen.count  = out_bus.valid_records;
                if (expected_verdicts.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: status %0d offset %0d stamp %h len %0d cnt %0d",
                                 seen.status, seen.offset, seen.stamp, seen.length, seen.count);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (seen.status !== want.status || seen.offset !== want.offset ||
                        seen.stamp !== want.stamp || seen.length !== want.length ||
                        seen.count !== want.count) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected status %0d offset %0d stamp %h len %0d cnt %0d",
                                     want.status, want.offset, want.stamp, want.length, want.count);
                            $display("          actual   status %0d offset %0d stamp %h len %0d cnt %0d",
                                     seen.status, seen.offset, seen.stamp, seen.length, seen.count);
                        end
                    end
                end
            end
            if (hold_left != 0) begin
                out_bus.ready <= 1'b0;
                hold_left     <= hold_left - 1;
            end else if (hold_req && !hold_done) begin
                out_bus.ready <= 1'b0;
                hold_left     <= 300;
                hold_done     <= 1'b1;
            end else begin
                out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic push_record(input bit rs, input logic [31:0] magic, input logic [63:0] stamp,
                               input logic [31:0] len, input int body_n, input bit spoil,
                               input int cut);
        logic [7:0]   rec_bytes[$];
        logic [159:0] hdr;
        logic [31:0]  c;
        logic [7:0]   b;
        hdr = {magic, stamp, len, 32'($urandom)};
        c = '1;
        for (int i = 0; i < HEADER_BYTES; i++) begin
            b = hdr[159 - 8 * i -: 8];
            c = crc32_shift(c, b);
            rec_bytes.push_back(b);
        end
        for (int i = 0; i < body_n; i++) begin
            b = 8'($urandom);
            c = crc32_shift(c, b);
            rec_bytes.push_back(b);
        end
        c = ~c;
        if (spoil) c = c ^ (32'h1 << $urandom_range(31));
        for (int i = 0; i < CRC_BYTES; i++) rec_bytes.push_back(c[31 - 8 * i -: 8]);
        for (int i = 0; i < rec_bytes.size() && i < cut; i++) begin
            byte_backlog.push_back({rec_bytes[i], rs && (i == 0)});
            pushed_bytes++;
        end
    endtask

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++) begin
            byte_backlog.push_back({8'($urandom), 1'b0});
            pushed_bytes++;
        end
    endtask

    function automatic logic [63:0] any_stamp();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RECORD_MAGIC) cfg_magic = value;
        else cfg_limit = value[15:0];
    endtask

    // block idle: nothing queued, nothing in flight, nothing owed
    task automatic wait_idle();
        while (byte_backlog.size() != 0 || in_bus.valid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic random_stream(input int nbytes);
        int          start;
        int          kind;
        int          cap;
        bit          need_rs;
        bit          rs;
        logic [31:0] len;
        logic [31:0] mg;
        logic [63:0] st;
        start   = pushed_bytes;
        need_rs = 1'b1;
        while (pushed_bytes - start < nbytes) begin
            kind = $urandom_range(99);
            rs   = need_rs || ($urandom_range(9) == 0);
            cap  = (cfg_limit > 12) ? 12 : int'(cfg_limit);
            len  = $urandom_range(0, cap);
            if ($urandom_range(9) == 0)
                len = $urandom_range(0, (cfg_limit > 400) ? 400 : int'(cfg_limit));
            if ($urandom_range(24) == 0 && cfg_limit <= 400) len = cfg_limit;
            st      = any_stamp();
            need_rs = 1'b0;
            if (kind < 70) begin
                push_record(rs, cfg_magic, st, len, len, 1'b0, CUT_NONE);
            end else if (kind < 78) begin
                push_record(rs, cfg_magic, st, len, len, 1'b1, CUT_NONE);
                need_rs = 1'b1;
            end else if (kind < 85) begin
                mg = $urandom_range(1) ? (cfg_magic ^ (32'h1 << $urandom_range(31)))
                                       : (cfg_magic ^ ($urandom | 32'h1));
                push_record(rs, mg, st, len, $urandom_range(0, 4), 1'b0, CUT_NONE);
                need_rs = 1'b1;
            end else if (kind < 92) begin
                len = $urandom_range(1) ? $urandom_range(32'hFFFF_FFFF, cfg_limit + 1)
                                        : cfg_limit + 1 + $urandom_range(0, 3);
                push_record(rs, cfg_magic, st, len, $urandom_range(0, 4), 1'b0, CUT_NONE);
                need_rs = 1'b1;
            end else begin
                // record cut short, the next one starts a new file
                push_record(rs, cfg_magic, st, len, len, 1'b0, $urandom_range(1, 23 + len));
                need_rs = 1'b1;
            end
            if (need_rs && $urandom_range(1)) push_noise($urandom_range(1, 6));
        end
    endtask

    initial begin
        cfg_magic  = '0;
        cfg_limit  = MAX_PAYLOAD_RESET;
        got_magic  = '0;
        got_stamp  = '0;
        got_length = '0;
        stream_pos = '0;
        rec_start  = '0;
        good_count = '0;
        open_record();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under reset registers: magic zero, default payload limit
        send_idle_pct = 35;
        recv_idle_pct = 70;
        push_record(1'b1, 32'h0, '1, 32'd0, 0, 1'b0, CUT_NONE);
        push_record(1'b0, 32'h0, '0, 32'd1, 1, 1'b0, CUT_NONE);
        push_record(1'b0, 32'h0, any_stamp(), 32'd3, 3, 1'b0, CUT_NONE);
        push_record(1'b0, 32'h0, any_stamp(), 32'd5, 5, 1'b0, 10);
        push_record(1'b1, 32'h0, any_stamp(), 32'd64, 64, 1'b0, CUT_NONE);
        push_record(1'b0, 32'h0, any_stamp(), 32'd65533, 3, 1'b0, CUT_NONE);
        // magic and length both bad: magic wins
        push_record(1'b1, 32'h1, any_stamp(), 32'hFFFF_FFFF, 0, 1'b0, CUT_NONE);
        push_record(1'b1, 32'h0, any_stamp(), 32'd2, 2, 1'b0, CUT_NONE);
        push_record(1'b0, 32'h0, any_stamp(), 32'd4, 4, 1'b1, CUT_NONE);
        push_noise(5);
        push_record(1'b1, 32'h0, any_stamp(), 32'd1, 1, 1'b0, CUT_NONE);
        push_record(1'b0, 32'h0, any_stamp(), 32'd6, 6, 1'b0, 28);
        push_record(1'b1, 32'h0, any_stamp(), 32'd0, 0, 1'b0, CUT_NONE);
        push_record(1'b0, 32'h0, any_stamp(), 32'h0001_0000, 0, 1'b0, CUT_NONE);
        wait_idle();

        write_reg(CFG_RECORD_MAGIC, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_PAYLOAD, {16'($urandom), 16'd0});
        push_record(1'b1, 32'hFFFF_FFFF, any_stamp(), 32'd0, 0, 1'b0, CUT_NONE);
        push_record(1'b0, 32'hFFFF_FFFF, any_stamp(), 32'd1, 1, 1'b0, CUT_NONE);
        push_record(1'b1, 32'hFFFF_FFFE, any_stamp(), 32'd0, 0, 1'b0, CUT_NONE);
        push_record(1'b1, 32'hFFFF_FFFF, any_stamp(), 32'd0, 0, 1'b0, CUT_NONE);
        wait_idle();

        for (int chunk = 0; chunk < 6; chunk++) begin
            case (chunk)
                0: begin
                    write_reg(CFG_RECORD_MAGIC, $urandom);
                    write_reg(CFG_MAX_PAYLOAD, 32'd65532);
                end
                1: begin
                    write_reg(CFG_RECORD_MAGIC, 32'hFFFF_FFFF);
                    write_reg(CFG_MAX_PAYLOAD, $urandom_range(0, 40));
                end
                2: begin
                    write_reg(CFG_RECORD_MAGIC, 32'h0);
                    write_reg(CFG_MAX_PAYLOAD, 32'd0);
                end
                3: begin
                    write_reg(CFG_RECORD_MAGIC, $urandom);
                    write_reg(CFG_MAX_PAYLOAD, $urandom_range(1, 300));
                end
                4: begin
                    write_reg(CFG_RECORD_MAGIC, $urandom);
                    write_reg(CFG_MAX_PAYLOAD, 32'd20);
                end
                default: begin
                    write_reg(CFG_RECORD_MAGIC, 32'hA5C3_5A3C);
                    write_reg(CFG_MAX_PAYLOAD, {16'hFFFF, 16'd65532});
                end
            endcase
            if (chunk < 2) begin
                send_idle_pct = 35;
                recv_idle_pct = 70;
            end else if (chunk < 4) begin
                send_idle_pct = 70;
                recv_idle_pct = 35;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long receiver hold-off while bytes keep coming
            if (chunk == 4) hold_req <= 1'b1;
            random_stream(170);
            wait_idle();
        end

        if (fail_count == 0 && expected_verdicts.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
